[rtl/rrca_pkg.sv]
// Shared types and constants for the reorder receiver with cumulative ack.
`timescale 1ns / 1ps

package rrca_pkg;

  // Field widths of the segment header and of the result record
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned TS_W   = 64;

  // Longest run of records that one segment may cause
  localparam int unsigned MAX_RESULTS = 10;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  // Ack number carried by the final ack
  localparam logic [SEQ_W-1:0] FINAL_ACK = '1;

  // Record kinds as seen on the output
  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_FINAL   = 2'd2
  } kind_e;

  // Class given to a segment by the front end
  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_END      = 2'd1,
    OP_OVERSIZE = 2'd2
  } op_e;

  // Queue entry between front and back
  typedef struct packed {
    logic [SEQ_W-1:0]  seqno;
    logic [SIZE_W-1:0] size;
    logic [TS_W-1:0]   timestamp;
    op_e               op;
  } seg_t;

  // One result record, slot travels alongside
  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              stored;
    logic              dropped;
    logic [SEQ_W-1:0]  ack;
    logic [TS_W-1:0]   echo;
    logic              last;
  } rec_t;

endpackage

[rtl/reorder_receiver_cumulative_ack.sv]
// Top level of the reorder receiver with cumulative acknowledgement.
// Input channel: one segment header per transfer (seg_seqno_i, seg_size_i,
// seg_timestamp_i) on in_valid_i / in_stall_o. Output channel: result
// records on out_valid_o / out_stall_i, each input ending in one record with
// last_o set (an ack, or the final ack once a zero-size segment was seen).
// A two-entry queue sits between the front end and the table sequencer, so
// headers keep arriving while a run is still being worked off.
// The first record of a segment is registered in the output stage once the
// sequencer pops it from the queue. A segment that is acked, stored or
// dropped is handled in S_IDLE alone. An in-order segment starts a chain of
// table passes: each pass walks the slots in S_ACCESS and checks each
// occupied slot in S_CHECK; a match restarts the pass from slot 0 until
// MAX_RESULTS - 2 matches are out, and the chain ends with the closing ack
// in S_ACK. The table is read through a registered port, which is why an
// occupied slot needs S_CHECK after S_ACCESS.
// Reset clears the expected offset, echoed timestamp, done flag and all
// table valid bits at once; no clearing pass is needed.
// While out_stall_i is high the held record stays put, the sequencer waits
// once it has a record to load, the queue fills and then in_stall_o rises.
`timescale 1ns / 1ps

module reorder_receiver_cumulative_ack import rrca_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [SEQ_W-1:0]                 seg_seqno_i,
  input  logic [SIZE_W-1:0]                seg_size_i,
  input  logic [TS_W-1:0]                  seg_timestamp_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [SEQ_W-1:0]                 deliver_offset_o,
  output logic [SIZE_W-1:0]                deliver_size_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] slot_o,
  output logic                             stored_o,
  output logic                             dropped_o,
  output logic [SEQ_W-1:0]                 ack_number_o,
  output logic [TS_W-1:0]                  echo_timestamp_o,
  output logic                             last_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH + 1);

  logic              q_valid;
  seg_t              q_item;
  logic              q_pop;
  logic              rec_free;
  logic              rec_load;
  rec_t              rec;
  logic [SLOT_W-1:0] rec_slot;

  rrca_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .seg_seqno_i     (seg_seqno_i),
    .seg_size_i      (seg_size_i),
    .seg_timestamp_i (seg_timestamp_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  rrca_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .rec_free_i (rec_free),
    .rec_load_o (rec_load),
    .rec_o      (rec),
    .rec_slot_o (rec_slot)
  );

  rrca_out #(
    .SLOT_W (SLOT_W)
  ) u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_load_i       (rec_load),
    .rec_i            (rec),
    .rec_slot_i       (rec_slot),
    .rec_free_o       (rec_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .deliver_offset_o (deliver_offset_o),
    .deliver_size_o   (deliver_size_o),
    .slot_o           (slot_o),
    .stored_o         (stored_o),
    .dropped_o        (dropped_o),
    .ack_number_o     (ack_number_o),
    .echo_timestamp_o (echo_timestamp_o),
    .last_o           (last_o)
  );

endmodule

[rtl/rrca_front.sv]
// Front end: accepts segment headers, classifies them and queues them.
`timescale 1ns / 1ps

module rrca_front import rrca_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SEQ_W-1:0]  seg_seqno_i,
  input  logic [SIZE_W-1:0] seg_size_i,
  input  logic [TS_W-1:0]   seg_timestamp_i,
  output logic              q_valid_o,
  output seg_t              q_item_o,
  input  logic              q_pop_i
);

  seg_t       item;
  seg_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  // Classify on size alone; order checks need back-end state
  always_comb begin
    item.seqno     = seg_seqno_i;
    item.size      = seg_size_i;
    item.timestamp = seg_timestamp_i;
    priority if (seg_size_i == '0) begin
      item.op = OP_END;
    end else if (SEQ_W'(seg_size_i) > SEQ_W'(MAX_PAYLOAD)) begin
      item.op = OP_OVERSIZE;
    end else begin
      item.op = OP_DATA;
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, q_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

[rtl/rrca_back.sv]
// Back end: expected offset, early-segment table and the search sequencer.
`timescale 1ns / 1ps

module rrca_back import rrca_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  seg_t                                q_item_i,
  output logic                                q_pop_o,
  input  logic                                rec_free_i,
  output logic                                rec_load_o,
  output rec_t                                rec_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]    rec_slot_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_CHECK  = 4'b0100,
    S_ACK    = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [SEQ_W-1:0]       exp_q, exp_d;
  logic [TS_W-1:0]        ts_q, ts_d;
  logic                   done_q, done_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic [SEQ_W-1:0]       mem_off  [TABLE_DEPTH];
  logic [SIZE_W-1:0]      mem_size [TABLE_DEPTH];
  logic [SEQ_W-1:0]       rd_off_q;
  logic [SIZE_W-1:0]      rd_size_q;
  logic                   wr_en;
  logic                   rd_en;

  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  // First free slot, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    exp_d      = exp_q;
    ts_d       = ts_q;
    done_d     = done_q;
    valid_d    = valid_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    q_pop_o    = 1'b0;
    rec_load_o = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rec_slot_o = SLOT_NONE;
    rec_o      = '{kind: KIND_ACK, offset: '0, size: '0, stored: 1'b0, dropped: 1'b0,
                   ack: exp_q, echo: ts_q, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && rec_free_i) begin
          q_pop_o    = 1'b1;
          rec_load_o = 1'b1;
          if (done_q || q_item_i.op == OP_END) begin
            // end of transfer, and everything after it
            done_d     = 1'b1;
            rec_o.kind = KIND_FINAL;
            rec_o.ack  = FINAL_ACK;
          end else if (q_item_i.op == OP_DATA) begin
            if (q_item_i.seqno == exp_q) begin
              // in order: deliver directly, then chain through the table
              ts_d         = q_item_i.timestamp;
              exp_d        = exp_q + SEQ_W'(q_item_i.size);
              rec_o.kind   = KIND_DELIVER;
              rec_o.offset = q_item_i.seqno;
              rec_o.size   = q_item_i.size;
              rec_o.ack    = exp_d;
              rec_o.echo   = q_item_i.timestamp;
              rec_o.last   = 1'b0;
              idx_d        = '0;
              cnt_d        = CNT_W'(1);
              state_d      = S_ACCESS;
            end else if (q_item_i.seqno > exp_q) begin
              // early: park in the table or drop
              if (free_found) begin
                wr_en             = 1'b1;
                valid_d[free_idx] = 1'b1;
                rec_slot_o        = SLOT_W'(free_idx);
                rec_o.stored      = 1'b1;
              end else begin
                rec_o.dropped = 1'b1;
              end
            end
          end
        end
      end

      S_ACCESS: begin
        // walk the slots; read only the occupied ones
        if (idx_q == SLOT_NONE) begin
          state_d = S_ACK;
        end else if (valid_q[idx_q[IDX_W-1:0]]) begin
          rd_en   = 1'b1;
          state_d = S_CHECK;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      S_CHECK: begin
        if (rd_off_q == exp_q) begin
          if (rec_free_i) begin
            valid_d[idx_q[IDX_W-1:0]] = 1'b0;
            exp_d        = exp_q + SEQ_W'(rd_size_q);
            rec_load_o   = 1'b1;
            rec_o.kind   = KIND_DELIVER;
            rec_o.offset = rd_off_q;
            rec_o.size   = rd_size_q;
            rec_o.ack    = exp_d;
            rec_o.last   = 1'b0;
            rec_slot_o   = idx_q;
            cnt_d        = cnt_q + CNT_W'(1);
            idx_d        = '0;
            // leave room for the closing ack
            if (cnt_d == CNT_W'(MAX_RESULTS - 1)) begin
              state_d = S_ACK;
            end else begin
              state_d = S_ACCESS;
            end
          end
        end else begin
          // stale entries are freed on the way
          if (rd_off_q < exp_q) begin
            valid_d[idx_q[IDX_W-1:0]] = 1'b0;
          end
          idx_d   = idx_q + SLOT_W'(1);
          state_d = S_ACCESS;
        end
      end

      S_ACK: begin
        if (rec_free_i) begin
          rec_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      exp_q   <= '0;
      ts_q    <= '0;
      done_q  <= 1'b0;
      valid_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      ts_q    <= ts_d;
      done_q  <= done_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // Table storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_off[free_idx]  <= q_item_i.seqno;
      mem_size[free_idx] <= q_item_i.size;
    end
    if (rd_en) begin
      rd_off_q  <= mem_off[idx_q[IDX_W-1:0]];
      rd_size_q <= mem_size[idx_q[IDX_W-1:0]];
    end
  end

endmodule

[rtl/rrca_out.sv]
// Output register: holds one result record for the downstream side.
`timescale 1ns / 1ps

module rrca_out import rrca_pkg::*; #(
  parameter int unsigned SLOT_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_load_i,
  input  rec_t              rec_i,
  input  logic [SLOT_W-1:0] rec_slot_i,
  output logic              rec_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [SEQ_W-1:0]  deliver_offset_o,
  output logic [SIZE_W-1:0] deliver_size_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              stored_o,
  output logic              dropped_o,
  output logic [SEQ_W-1:0]  ack_number_o,
  output logic [TS_W-1:0]   echo_timestamp_o,
  output logic              last_o
);

  logic              valid_q, valid_d;
  rec_t              rec_q;
  logic [SLOT_W-1:0] slot_q;

  // Free when empty or when the held record leaves this cycle
  assign rec_free_o = !valid_q || !out_stall_i;

  always_comb begin
    priority if (rec_load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_load_i) begin
      rec_q  <= rec_i;
      slot_q <= rec_slot_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = rec_q.kind;
  assign deliver_offset_o = rec_q.offset;
  assign deliver_size_o   = rec_q.size;
  assign slot_o           = slot_q;
  assign stored_o         = rec_q.stored;
  assign dropped_o        = rec_q.dropped;
  assign ack_number_o     = rec_q.ack;
  assign echo_timestamp_o = rec_q.echo;
  assign last_o           = rec_q.last;

endmodule

[sim/tb_reorder_receiver_cumulative_ack.sv]
// Testbench for the reorder receiver: segment stimulus, in-line predictor and record checker.
`timescale 1ns / 1ps

module tb_reorder_receiver_cumulative_ack;
  import rrca_pkg::*;

  localparam int unsigned TBL_DEPTH    = 8;
  localparam int unsigned SEG_MAX      = 1024;
  localparam int unsigned SLOT_W       = $clog2(TBL_DEPTH + 1);
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(TBL_DEPTH);
  localparam int unsigned HEAD_ROWS    = 20;
  localparam int unsigned TAIL_ROWS    = 4;
  localparam int unsigned RAND_ITEMS   = 290;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned FAR_ITEMS    = 30;
  localparam int unsigned DRAIN_CYCLES = 250;

  // One expected output record
  typedef struct {
    kind_e              kind;
    logic [SEQ_W-1:0]   offset;
    logic [SIZE_W-1:0]  size;
    logic [SLOT_W-1:0]  slot;
    logic               stored;
    logic               dropped;
    logic [SEQ_W-1:0]   ack;
    logic [TS_W-1:0]    echo;
    logic               last;
  } rx_rec_t;

  // Directed stimulus row; chk marks a typed-in closing record
  typedef struct {
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [TS_W-1:0]   ts;
    bit                chk;
    kind_e             kind;
    logic [SEQ_W-1:0]  ack;
  } seg_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [SEQ_W-1:0]        seg_seqno_i = '0;
  logic [SIZE_W-1:0]       seg_size_i = '0;
  logic [TS_W-1:0]         seg_timestamp_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              kind_o;
  logic [SEQ_W-1:0]        deliver_offset_o;
  logic [SIZE_W-1:0]       deliver_size_o;
  logic [SLOT_W-1:0]       slot_o;
  logic                    stored_o;
  logic                    dropped_o;
  logic [SEQ_W-1:0]        ack_number_o;
  logic [TS_W-1:0]         echo_timestamp_o;
  logic                    last_o;

  // Predictor state
  logic [SEQ_W-1:0]  next_off;
  logic [TS_W-1:0]   echo_ts;
  bit                held      [TBL_DEPTH];
  logic [SEQ_W-1:0]  held_off  [TBL_DEPTH];
  logic [SIZE_W-1:0] held_size [TBL_DEPTH];
  bit                fin_seen;

  rx_rec_t due_records[$];
  rx_rec_t want_rec;
  int      errors;
  int      stall_cnt;
  bit      quiet;

  // Directed rows: head runs first, tail closes the transfer after the random part
  seg_row_t seg_rows [0:HEAD_ROWS+TAIL_ROWS-1] = '{
    // in-order at offset zero, all-ones timestamp
    '{32'd0,    11'd1024, '1,                    1'b1, KIND_ACK,   32'd1024},
    // late duplicate
    '{32'd0,    11'd5,    64'd0,                 1'b1, KIND_ACK,   32'd1024},
    // oversize segments
    '{32'd1024, 11'd1025, 64'd1,                 1'b1, KIND_ACK,   32'd1024},
    '{32'd1024, 11'd2047, 64'd2,                 1'b1, KIND_ACK,   32'd1024},
    // fill the table back to front
    '{32'd1032, 11'd1,    64'd10,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1031, 11'd1,    64'd11,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1030, 11'd1,    64'd12,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1029, 11'd1,    64'd13,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1028, 11'd1,    64'd14,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1027, 11'd1,    64'd15,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1026, 11'd1,    64'd16,                1'b1, KIND_ACK,   32'd1024},
    '{32'd1025, 11'd1,    64'd17,                1'b1, KIND_ACK,   32'd1024},
    // table full, early segment dropped
    '{32'd2000, 11'd10,   64'd18,                1'b1, KIND_ACK,   32'd1024},
    // gap filled, longest chain drains the whole table
    '{32'd1024, 11'd1,    64'h0123_4567_89AB_CDEF, 1'b1, KIND_ACK,   32'd1033},
    // two entries that an overlapping segment makes stale
    '{32'd1100, 11'd50,   64'd20,                1'b0, KIND_ACK,   32'd0},
    '{32'd1040, 11'd10,   64'd21,                1'b0, KIND_ACK,   32'd0},
    '{32'd1033, 11'd100,  64'd22,                1'b1, KIND_ACK,   32'd1133},
    // chain found out of slot order
    '{32'd1200, 11'd5,    64'd23,                1'b0, KIND_ACK,   32'd0},
    '{32'd1140, 11'd60,   64'd24,                1'b0, KIND_ACK,   32'd0},
    '{32'd1133, 11'd7,    64'd25,                1'b1, KIND_ACK,   32'd1205},
    // tail: far-future segment, end of transfer, inputs after done
    '{'1,       11'd1024, 64'hFEDC_BA98_7654_3210, 1'b0, KIND_ACK,   32'd0},
    '{32'd0,    11'd0,    64'hDEAD_BEEF_0000_0001, 1'b1, KIND_FINAL, FINAL_ACK},
    '{32'd0,    11'd1,    64'd30,                1'b1, KIND_FINAL, FINAL_ACK},
    '{'1,       11'd2047, '1,                    1'b1, KIND_FINAL, FINAL_ACK}
  };

  reorder_receiver_cumulative_ack #(
    .TABLE_DEPTH (TBL_DEPTH),
    .MAX_PAYLOAD (SEG_MAX)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .seg_seqno_i      (seg_seqno_i),
    .seg_size_i       (seg_size_i),
    .seg_timestamp_i  (seg_timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .deliver_offset_o (deliver_offset_o),
    .deliver_size_o   (deliver_size_o),
    .slot_o           (slot_o),
    .stored_o         (stored_o),
    .dropped_o        (dropped_o),
    .ack_number_o     (ack_number_o),
    .echo_timestamp_o (echo_timestamp_o),
    .last_o           (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Queue one expected record, echo taken from the current latch
  function automatic void post_record(input kind_e kind, input logic [SEQ_W-1:0] off,
                                      input logic [SIZE_W-1:0] size,
                                      input logic [SLOT_W-1:0] slot, input logic st,
                                      input logic dr, input logic [SEQ_W-1:0] ack,
                                      input logic last);
    rx_rec_t r;
    r.kind    = kind;
    r.offset  = off;
    r.size    = size;
    r.slot    = slot;
    r.stored  = st;
    r.dropped = dr;
    r.ack     = ack;
    r.echo    = echo_ts;
    r.last    = last;
    due_records.push_back(r);
  endfunction

  // Work out the records caused by one accepted segment
  function automatic void absorb_segment(input logic [SEQ_W-1:0] seq,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [TS_W-1:0] ts);
    int                n;
    int                hit;
    logic [SLOT_W-1:0] put_slot;
    logic              st;
    logic              dr;
    n        = 0;
    put_slot = NO_SLOT;
    st       = 1'b0;
    dr       = 1'b0;
    if (fin_seen || size == '0) begin
      fin_seen = 1'b1;
      post_record(KIND_FINAL, '0, '0, NO_SLOT, 1'b0, 1'b0, FINAL_ACK, 1'b1);
      return;
    end
    if (size <= SEG_MAX) begin
      if (seq == next_off) begin
        // in order: deliver, then chain through the table
        echo_ts  = ts;
        next_off = next_off + size;
        post_record(KIND_DELIVER, seq, size, NO_SLOT, 1'b0, 1'b0, next_off, 1'b0);
        n = 1;
        while (n < MAX_RESULTS - 1) begin
          hit = -1;
          for (int i = 0; i < TBL_DEPTH; i++) begin
            if (held[i] && hit < 0) begin
              if (held_off[i] == next_off) begin
                held[i] = 1'b0;
                hit     = i;
              end else if (held_off[i] < next_off) begin
                held[i] = 1'b0;
              end
            end
          end
          if (hit < 0) break;
          next_off = next_off + held_size[hit];
          post_record(KIND_DELIVER, held_off[hit], held_size[hit], SLOT_W'(hit), 1'b0, 1'b0,
                      next_off, 1'b0);
          n++;
        end
      end else if (seq > next_off) begin
        // early: first free slot, else dropped
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (!held[i] && !st) begin
            held[i]      = 1'b1;
            held_off[i]  = seq;
            held_size[i] = size;
            put_slot     = SLOT_W'(i);
            st           = 1'b1;
          end
        end
        dr = !st;
      end
    end
    post_record(KIND_ACK, '0, '0, put_slot, st, dr, next_off, 1'b1);
  endfunction

  function automatic void match_field(input string name, input logic [TS_W-1:0] want,
                                      input logic [TS_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Drive one segment, optionally after a gap, and wait for its transfer
  task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [SIZE_W-1:0] size,
                              input logic [TS_W-1:0] ts);
    bit taken;
    taken = 1'b0;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    seg_seqno_i     <= seq;
    seg_size_i      <= size;
    seg_timestamp_i <= ts;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    absorb_segment(seq, size, ts);
  endtask

  // Send a directed row and check its typed-in closing record
  task automatic run_row(input int r);
    send_segment(seg_rows[r].seq, seg_rows[r].size, seg_rows[r].ts);
    if (seg_rows[r].chk &&
        (due_records[$].kind != seg_rows[r].kind || due_records[$].ack != seg_rows[r].ack)) begin
      errors++;
      $display("%0t: row %0d closing record, expected kind %0d ack %h, actual kind %0d ack %h",
               $time, r, seg_rows[r].kind, seg_rows[r].ack, due_records[$].kind,
               due_records[$].ack);
    end
  endtask

  // Output stall bursts
  always @(posedge clk_i) begin
    if (stall_cnt != 0) begin
      stall_cnt = stall_cnt - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(1, 9);
    end
    out_stall_i <= (stall_cnt != 0);
  end

  // Record checker: inputs only move at the rising edge, so sample in between
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual kind %0d ack %h",
                 $time, kind_o, ack_number_o);
      end else begin
        want_rec = due_records.pop_front();
        match_field("kind", TS_W'(want_rec.kind), TS_W'(kind_o));
        match_field("deliver_offset", TS_W'(want_rec.offset), TS_W'(deliver_offset_o));
        match_field("deliver_size", TS_W'(want_rec.size), TS_W'(deliver_size_o));
        match_field("slot", TS_W'(want_rec.slot), TS_W'(slot_o));
        match_field("stored", TS_W'(want_rec.stored), TS_W'(stored_o));
        match_field("dropped", TS_W'(want_rec.dropped), TS_W'(dropped_o));
        match_field("ack_number", TS_W'(want_rec.ack), TS_W'(ack_number_o));
        match_field("echo_timestamp", want_rec.echo, echo_timestamp_o);
        match_field("last", TS_W'(want_rec.last), TS_W'(last_o));
      end
    end
  end

  // Main sequence
  initial begin
    int                k;
    int                skip;
    int                sent;
    int                pick;
    int                w;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  base;
    logic [SIZE_W-1:0] size;
    logic [SEQ_W-1:0]  win_seq  [6];
    logic [SIZE_W-1:0] win_size [6];
    logic [SEQ_W-1:0]  tmp_seq;
    logic [SIZE_W-1:0] tmp_size;

    errors    = 0;
    stall_cnt = 0;
    quiet     = 1'b0;
    next_off  = '0;
    echo_ts   = '0;
    fin_seen  = 1'b0;
    foreach (held[i]) held[i] = 1'b0;
    sent = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < HEAD_ROWS; r++) run_row(r);

    // Random part: mostly shuffled in-sequence windows, some noise
    while (sent < RAND_ITEMS) begin
      quiet = (sent >= RAND_ITEMS - CALM_ITEMS);
      pick  = $urandom_range(0, 9);
      if (pick < 7) begin
        k    = $urandom_range(1, 6);
        base = next_off;
        for (int j = 0; j < k; j++) begin
          win_size[j] = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(1, 16))
                                                     : SIZE_W'($urandom_range(1, SEG_MAX));
          win_seq[j]  = base;
          base        = base + win_size[j];
        end
        for (int j = k - 1; j > 0; j--) begin
          w           = $urandom_range(0, j);
          tmp_seq     = win_seq[j];
          tmp_size    = win_size[j];
          win_seq[j]  = win_seq[w];
          win_size[j] = win_size[w];
          win_seq[w]  = tmp_seq;
          win_size[w] = tmp_size;
        end
        // now and then a segment goes missing
        skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, k - 1) : -1;
        for (int j = 0; j < k; j++) begin
          if (j != skip) begin
            send_segment(win_seq[j], win_size[j], {$urandom, $urandom});
            sent++;
          end
        end
      end else begin
        size = SIZE_W'($urandom_range(1, SEG_MAX));
        if (pick == 7) begin
          // late duplicate
          if (next_off != 0)
            seq = next_off - $urandom_range(1, (next_off > 4096) ? 4096 : next_off);
          else
            seq = next_off;
        end else if (pick == 8) begin
          // oversize
          size = SIZE_W'($urandom_range(SEG_MAX + 1, (1 << SIZE_W) - 1));
          seq  = ($urandom_range(0, 1) == 0) ? next_off : SEQ_W'($urandom);
        end else if (sent >= RAND_ITEMS - FAR_ITEMS) begin
          // far ahead, anywhere in the sequence space
          seq = $urandom;
        end else begin
          // near ahead, may overlap later windows
          seq = next_off + $urandom_range(1, 3000);
        end
        send_segment(seq, size, {$urandom, $urandom});
        sent++;
      end
    end

    quiet = 1'b1;
    for (int r = HEAD_ROWS; r < HEAD_ROWS + TAIL_ROWS; r++) run_row(r);
    in_valid_i <= 1'b0;

    while (due_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/rrca_pkg.sv
rtl/rrca_front.sv
rtl/rrca_back.sv
rtl/rrca_out.sv
rtl/reorder_receiver_cumulative_ack.sv
sim/tb_reorder_receiver_cumulative_ack.sv
